// File: design/bris_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear RGB image scaler: shared package
// Field widths, default parameter values, register indexes and pixel type.
// ----------------------------------------------------------------------------
package bris_pkg;

  // Fixed field widths of the ports.
  localparam int COORD_W = 12;
  localparam int CFG_W   = 13;
  localparam int SRC_C_W = 9;
  localparam int CH_W    = 8;

  // Default parameter values.
  localparam int SRC_WIDTH_DEF   = 384;
  localparam int SRC_HEIGHT_DEF  = 288;
  localparam int MAX_OUT_DIM_DEF = 4096;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd384;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd288;

  // Alpha is constant.
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [0:0] {
    CFG_OUT_WIDTH  = 1'b0,
    CFG_OUT_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // Quotient width of the position dividers, sized for the larger source dimension.
  function automatic int num_width(input int src_w, input int src_h);
    int wb;
    int hb;
    wb = $clog2(src_w);
    hb = $clog2(src_h);
    return COORD_W + ((wb > hb) ? wb : hb) + 8;
  endfunction

endpackage

// File: design/bris_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, MSB first; a new division enters every cycle.
// ----------------------------------------------------------------------------
module bris_div #(
  parameter int NUM_W = 29,
  parameter int DIV_W = 13
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0] div_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] num_s [NUM_W+1];
  logic [NUM_W-1:0] quo_s [NUM_W+1];
  logic [DIV_W-1:0] rem_s [NUM_W+1];
  logic [DIV_W-1:0] div_s [NUM_W+1];

  assign num_s[0] = num_i;
  assign quo_s[0] = '0;
  assign rem_s[0] = '0;
  assign div_s[0] = div_i;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [NUM_W-1:0] num_q;
    logic [NUM_W-1:0] quo_q;
    logic [DIV_W-1:0] rem_q;
    logic [DIV_W-1:0] div_q;

    // Shift in the next numerator bit and try one subtraction.
    always_comb begin
      trial = {rem_s[k], num_s[k][NUM_W-1]};
      diff  = trial - {1'b0, div_s[k]};
      ge    = (trial >= {1'b0, div_s[k]});
    end

    always_ff @(posedge clk_i) begin
      num_q <= {num_s[k][NUM_W-2:0], 1'b0};
      quo_q <= {quo_s[k][NUM_W-2:0], ge};
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      div_q <= div_s[k];
    end

    assign num_s[k+1] = num_q;
    assign quo_s[k+1] = quo_q;
    assign rem_s[k+1] = rem_q;
    assign div_s[k+1] = div_q;
  end

  assign quo_o = quo_s[NUM_W];

endmodule

// File: design/bris_bank.sv
// ----------------------------------------------------------------------------
// Source pixel bank
// One of four parity banks; one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module bris_bank
  import bris_pkg::*;
#(
  parameter int DEPTH = 27648,
  parameter int AW    = 15
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  pixel_t        wdata_i,
  output pixel_t        rdata_o
);

  pixel_t mem [DEPTH];

  // Write on a load, registered read for a query.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: design/bris_mix.sv
// ----------------------------------------------------------------------------
// Bilinear mixer
// Horizontal mix of both rows in the first stage, vertical mix in the second.
// ----------------------------------------------------------------------------
module bris_mix
  import bris_pkg::*;
(
  input  logic      clk_i,
  input  pixel_t    p00_i,
  input  pixel_t    p01_i,
  input  pixel_t    p10_i,
  input  pixel_t    p11_i,
  input  logic [7:0] fx_i,
  input  logic [7:0] fy_i,
  output pixel_t    pix_o
);

  // a + floor((b - a) * f / 256); the result always lies between a and b.
  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [7:0] f);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    logic signed [9:0]  s;
    logic signed [9:0]  r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    s = 10'(p >>> 8);
    r = $signed({2'b00, a}) + s;
    return r[CH_W-1:0];
  endfunction

  pixel_t     t0_q;
  pixel_t     t1_q;
  logic [7:0] fy_q;

  // Horizontal stage.
  always_ff @(posedge clk_i) begin
    t0_q.red   <= lerp(p00_i.red,   p01_i.red,   fx_i);
    t0_q.green <= lerp(p00_i.green, p01_i.green, fx_i);
    t0_q.blue  <= lerp(p00_i.blue,  p01_i.blue,  fx_i);
    t1_q.red   <= lerp(p10_i.red,   p11_i.red,   fx_i);
    t1_q.green <= lerp(p10_i.green, p11_i.green, fx_i);
    t1_q.blue  <= lerp(p10_i.blue,  p11_i.blue,  fx_i);
    fy_q       <= fy_i;
  end

  // Vertical stage.
  always_ff @(posedge clk_i) begin
    pix_o.red   <= lerp(t0_q.red,   t1_q.red,   fy_q);
    pix_o.green <= lerp(t0_q.green, t1_q.green, fy_q);
    pix_o.blue  <= lerp(t0_q.blue,  t1_q.blue,  fy_q);
  end

endmodule

// File: design/bilinear_rgb_image_scaler.sv
// ----------------------------------------------------------------------------
// Bilinear RGB image scaler
// Holds the source image in four parity banks and answers output pixel
// queries by bilinear interpolation, one request per cycle.
// ----------------------------------------------------------------------------
// Pipeline: a query result appears on valid_o after the request, scale,
// divider, clamp, bank coordinate, address, bank and both mix stages.
// Throughput: one request per cycle, loads and queries mixed freely.
// Reset clears the pipeline valid bits and returns the size registers to
// 384 x 288; the pixel store holds no reset value. The receiver cannot
// stall, so busy stays low.
module bilinear_rgb_image_scaler
  import bris_pkg::*;
#(
  parameter int SRC_WIDTH   = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT  = SRC_HEIGHT_DEF,
  parameter int MAX_OUT_DIM = MAX_OUT_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [SRC_C_W-1:0] src_col_i,
  input  logic [SRC_C_W-1:0] src_row_i,
  input  logic [CH_W-1:0]    red_in_i,
  input  logic [CH_W-1:0]    green_in_i,
  input  logic [CH_W-1:0]    blue_in_i,
  input  logic [COORD_W-1:0] out_col_i,
  input  logic [COORD_W-1:0] out_row_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output logic               valid_o,
  output logic [CH_W-1:0]    alpha_out_o,
  output logic [CH_W-1:0]    red_out_o,
  output logic [CH_W-1:0]    green_out_o,
  output logic [CH_W-1:0]    blue_out_o
);

  localparam int NUM_W = num_width(SRC_WIDTH, SRC_HEIGHT);
  localparam int PRD_W = NUM_W - 8;
  localparam int XW    = $clog2(SRC_WIDTH);
  localparam int YW    = $clog2(SRC_HEIGHT);
  localparam int HW    = (SRC_WIDTH + 1) / 2;
  localparam int HH    = (SRC_HEIGHT + 1) / 2;
  localparam int DEPTH = HW * HH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DLEN  = NUM_W + 2;

  typedef struct packed {
    logic               cmd;
    logic [SRC_C_W-1:0] col;
    logic [SRC_C_W-1:0] row;
    pixel_t             pix;
  } load_t;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers, saturated to the largest output size.
  logic [CFG_W-1:0] out_w_q, out_h_q;
  logic [CFG_W-1:0] cfg_sat;

  always_comb begin
    if (32'(cfg_data_i) > MAX_OUT_DIM) begin
      cfg_sat = CFG_W'(MAX_OUT_DIM);
    end else begin
      cfg_sat = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_w_q <= OUT_WIDTH_RST;
      out_h_q <= OUT_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_OUT_WIDTH:  out_w_q <= cfg_sat;
        CFG_OUT_HEIGHT: out_h_q <= cfg_sat;
        default: ;
      endcase
    end
  end

  // Request stage: capture fields and the two divisors.
  logic               acc;
  logic [COORD_W-1:0] ocol_q, orow_q;
  logic [CFG_W-1:0]   divx0_q, divy0_q, divx1_q, divy1_q;
  logic [NUM_W-1:0]   numx_q, numy_q;
  load_t              line_q [DLEN];
  logic [DLEN-1:0]    vld_q;

  assign acc = start && !busy;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_q[0] <= '{cmd: cmd_i, col: src_col_i, row: src_row_i,
                     pix: '{red: red_in_i, green: green_in_i, blue: blue_in_i}};
      ocol_q    <= out_col_i;
      orow_q    <= out_row_i;
      divx0_q   <= (out_w_q > CFG_W'(1)) ? out_w_q - CFG_W'(1) : CFG_W'(1);
      divy0_q   <= (out_h_q > CFG_W'(1)) ? out_h_q - CFG_W'(1) : CFG_W'(1);
    end
  end

  // Scale stage: coord * (SRC - 1) * 256.
  always_ff @(posedge clk_i) begin
    numx_q  <= {PRD_W'(ocol_q) * PRD_W'(SRC_WIDTH - 1), 8'h00};
    numy_q  <= {PRD_W'(orow_q) * PRD_W'(SRC_HEIGHT - 1), 8'h00};
    divx1_q <= divx0_q;
    divy1_q <= divy0_q;
  end

  // Load fields and valid bits ride along with the divider.
  always_ff @(posedge clk_i) begin
    for (int k = 1; k < DLEN; k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DLEN-2:0], acc};
    end
  end

  logic [NUM_W-1:0] qx, qy;

  bris_div #(.NUM_W(NUM_W), .DIV_W(CFG_W)) u_div_x (
    .clk_i (clk_i),
    .num_i (numx_q),
    .div_i (divx1_q),
    .quo_o (qx)
  );

  bris_div #(.NUM_W(NUM_W), .DIV_W(CFG_W)) u_div_y (
    .clk_i (clk_i),
    .num_i (numy_q),
    .div_i (divy1_q),
    .quo_o (qy)
  );

  // Clamp stage: index and fraction, or the load position.
  load_t           ld2_q;
  logic            v2_q, q2_q, we2_q;
  logic [XW-1:0]   xi2_q;
  logic [YW-1:0]   yi2_q;
  logic [7:0]      fx2_q, fy2_q;
  load_t           ldn;

  assign ldn = line_q[DLEN-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= vld_q[DLEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ld2_q <= ldn;
    q2_q  <= (cmd_e'(ldn.cmd) == CMD_QUERY);
    we2_q <= (cmd_e'(ldn.cmd) == CMD_LOAD) && (32'(ldn.col) < SRC_WIDTH)
             && (32'(ldn.row) < SRC_HEIGHT);
    if (cmd_e'(ldn.cmd) == CMD_QUERY) begin
      if (qx[NUM_W-1:8] > PRD_W'(SRC_WIDTH - 2)) begin
        xi2_q <= XW'(SRC_WIDTH - 2);
        fx2_q <= 8'h00;
      end else begin
        xi2_q <= qx[XW+7:8];
        fx2_q <= qx[7:0];
      end
      if (qy[NUM_W-1:8] > PRD_W'(SRC_HEIGHT - 2)) begin
        yi2_q <= YW'(SRC_HEIGHT - 2);
        fy2_q <= 8'h00;
      end else begin
        yi2_q <= qy[YW+7:8];
        fy2_q <= qy[7:0];
      end
    end else begin
      xi2_q <= XW'(ldn.col);
      yi2_q <= YW'(ldn.row);
      fx2_q <= 8'h00;
      fy2_q <= 8'h00;
    end
  end

  // Bank coordinate stage: for each parity, the neighbor column and row.
  logic            v3_q, q3_q, we3_q;
  pixel_t          pix3_q;
  logic            px3_q, py3_q;
  logic [XW-1:0]   hc3_q [2];
  logic [YW-1:0]   hr3_q [2];
  logic [7:0]      fx3_q, fy3_q;
  logic [XW-1:0]   xi2_n;
  logic [YW-1:0]   yi2_n;

  assign xi2_n = xi2_q + XW'(1);
  assign yi2_n = yi2_q + YW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q3_q   <= q2_q;
    we3_q  <= we2_q && v2_q;
    pix3_q <= ld2_q.pix;
    px3_q  <= xi2_q[0];
    py3_q  <= yi2_q[0];
    fx3_q  <= fx2_q;
    fy3_q  <= fy2_q;
    for (int p = 0; p < 2; p++) begin
      hc3_q[p] <= ((xi2_q[0] == p[0]) ? xi2_q : xi2_n) >> 1;
      hr3_q[p] <= ((yi2_q[0] == p[0]) ? yi2_q : yi2_n) >> 1;
    end
  end

  // Address stage: row-major address inside each parity bank.
  logic            v4_q, q4_q;
  logic [3:0]      we4_q;
  pixel_t          pix4_q;
  logic            px4_q, py4_q;
  logic [AW-1:0]   addr4_q [4];
  logic [7:0]      fx4_q, fy4_q;
  logic [AW-1:0]   rbase [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      rbase[p] = AW'(32'(hr3_q[p]) * HW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q4_q   <= q3_q;
    pix4_q <= pix3_q;
    px4_q  <= px3_q;
    py4_q  <= py3_q;
    fx4_q  <= fx3_q;
    fy4_q  <= fy3_q;
    for (int b = 0; b < 4; b++) begin
      addr4_q[b] <= rbase[b/2] + AW'(hc3_q[b%2]);
      we4_q[b]   <= we3_q && ({py3_q, px3_q} == 2'(b));
    end
  end

  // Bank stage: write a load, read four neighbors for a query.
  pixel_t rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bris_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank (
      .clk_i   (clk_i),
      .we_i    (we4_q[b]),
      .addr_i  (addr4_q[b]),
      .wdata_i (pix4_q),
      .rdata_o (rd[b])
    );
  end

  logic       v5_q, q5_q, px5_q, py5_q;
  logic [7:0] fx5_q, fy5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q5_q  <= q4_q;
    px5_q <= px4_q;
    py5_q <= py4_q;
    fx5_q <= fx4_q;
    fy5_q <= fy4_q;
  end

  // Mix stages.
  pixel_t mix;
  logic   v6_q, v7_q;

  bris_mix u_mix (
    .clk_i (clk_i),
    .p00_i (rd[{py5_q, px5_q}]),
    .p01_i (rd[{py5_q, ~px5_q}]),
    .p10_i (rd[{~py5_q, px5_q}]),
    .p11_i (rd[{~py5_q, ~px5_q}]),
    .fx_i  (fx5_q),
    .fy_i  (fy5_q),
    .pix_o (mix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v6_q <= v5_q && q5_q;
      v7_q <= v6_q;
    end
  end

  assign valid_o     = v7_q;
  assign alpha_out_o = ALPHA_OPAQUE;
  assign red_out_o   = mix.red;
  assign green_out_o = mix.green;
  assign blue_out_o  = mix.blue;

endmodule

// File: design/bris_chk.sv
// ----------------------------------------------------------------------------
// Bilinear RGB image scaler: port checker
// Checks result timing and constant port behavior, bound to the top level.
// ----------------------------------------------------------------------------
module bris_chk
  import bris_pkg::*;
#(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            cmd_i,
  input logic            cfg_ready_o,
  input logic            valid_o,
  input logic [CH_W-1:0] alpha_out_o
);

  localparam int LAT = num_width(SRC_WIDTH, SRC_HEIGHT) + 8;

  logic qry_req;
  assign qry_req = start && !busy && (cmd_e'(cmd_i) == CMD_QUERY);

  // Every result answers a query request a fixed latency earlier.
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(qry_req, LAT))
    else $error("result without a matching query request");

  // Results always carry an opaque alpha.
  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (alpha_out_o == ALPHA_OPAQUE))
    else $error("alpha not opaque");

  // Neither request channel is ever held off.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("request channel held off");

endmodule

bind bilinear_rgb_image_scaler bris_chk #(
  .SRC_WIDTH  (SRC_WIDTH),
  .SRC_HEIGHT (SRC_HEIGHT)
) u_bris_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .cfg_ready_o (cfg_ready_o),
  .valid_o     (valid_o),
  .alpha_out_o (alpha_out_o)
);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Bilinear RGB image scaler testbench
// A driver sends load and query requests from a queue. A monitor checks each
// output pixel against a bilinear prediction made from the testbench's own
// copy of the source image and output size. Several output sizes are set,
// including the smallest, the largest and oversized register values.
// ----------------------------------------------------------------------------
module testbench
  import bris_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SRC_W      = SRC_WIDTH_DEF;
  localparam int SRC_H      = SRC_HEIGHT_DEF;
  localparam int NUM_PIX    = SRC_W * SRC_H;
  localparam int SETTLE_CYC = 80;

  typedef struct packed {
    cmd_e               cmd;
    logic [SRC_C_W-1:0] scol;
    logic [SRC_C_W-1:0] srow;
    pixel_t             px;
    logic [COORD_W-1:0] ocol;
    logic [COORD_W-1:0] orow;
  } request_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd_i = CMD_LOAD;
  logic [SRC_C_W-1:0] src_col_i = '0;
  logic [SRC_C_W-1:0] src_row_i = '0;
  logic [CH_W-1:0]    red_in_i = '0;
  logic [CH_W-1:0]    green_in_i = '0;
  logic [CH_W-1:0]    blue_in_i = '0;
  logic [COORD_W-1:0] out_col_i = '0;
  logic [COORD_W-1:0] out_row_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = CFG_OUT_WIDTH;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               valid_o;
  logic [CH_W-1:0]    alpha_out_o, red_out_o, green_out_o, blue_out_o;

  bilinear_rgb_image_scaler DUT (.*);

  // Predictor state: source image and active output size.
  pixel_t      src_image [NUM_PIX];
  int unsigned frame_w = OUT_WIDTH_RST;
  int unsigned frame_h = OUT_HEIGHT_RST;

  // Stimulus side: what has been loaded so far, and the size in effect.
  bit          loaded [NUM_PIX];
  int unsigned gen_w = OUT_WIDTH_RST;
  int unsigned gen_h = OUT_HEIGHT_RST;

  request_t pending_reqs[$];
  pixel_t   expected_pix[$];
  int       errors = 0;
  int       n_loads = 0;
  int       n_queries = 0;
  int       n_checked = 0;
  bit       no_gaps = 1'b0;
  bit       hold_sender = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Source index and 8-bit fraction along one axis, clamped at the last pair.
  function automatic void map_axis(input int unsigned coord, input int unsigned outsz,
                                   input int unsigned srcsz, output int unsigned idx,
                                   output int frac);
    longint unsigned dv, q, i;
    dv = (outsz > 1) ? longint'(outsz - 1) : 64'd1;
    q = (longint'(coord) * longint'(srcsz - 1) * 256) / dv;
    i = q >> 8;
    if (i > srcsz - 2) begin
      i = srcsz - 2;
      q = longint'(srcsz - 1) * 256;
    end
    idx = int'(i);
    frac = int'(q & 255);
  endfunction

  function automatic int blend(input int a, input int b, input int f);
    return a + (((b - a) * f) >>> 8);
  endfunction

  function automatic pixel_t scale_pixel(input request_t r);
    int unsigned xi, yi;
    int          fx, fy;
    pixel_t      p00, p01, p10, p11, res;
    map_axis(r.ocol, frame_w, SRC_W, xi, fx);
    map_axis(r.orow, frame_h, SRC_H, yi, fy);
    p00 = src_image[yi * SRC_W + xi];
    p01 = src_image[yi * SRC_W + xi + 1];
    p10 = src_image[(yi + 1) * SRC_W + xi];
    p11 = src_image[(yi + 1) * SRC_W + xi + 1];
    res.red   = 8'(blend(blend(p00.red, p01.red, fx), blend(p10.red, p11.red, fx), fy));
    res.green = 8'(blend(blend(p00.green, p01.green, fx),
                         blend(p10.green, p11.green, fx), fy));
    res.blue  = 8'(blend(blend(p00.blue, p01.blue, fx), blend(p10.blue, p11.blue, fx), fy));
    return res;
  endfunction

  function automatic int unsigned sat_size(input logic [CFG_W-1:0] v);
    return (v > MAX_OUT_DIM_DEF) ? MAX_OUT_DIM_DEF : int'(v);
  endfunction

  // Driver: retire the accepted request, then present the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (pending_reqs[0].cmd == CMD_LOAD) begin
          if (pending_reqs[0].scol < SRC_W && pending_reqs[0].srow < SRC_H)
            src_image[pending_reqs[0].srow * SRC_W + pending_reqs[0].scol] = pending_reqs[0].px;
          n_loads++;
        end else begin
          expected_pix.push_back(scale_pixel(pending_reqs[0]));
          n_queries++;
        end
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && !hold_sender &&
          (no_gaps || $urandom_range(0, 99) >= 33)) begin
        start      <= 1'b1;
        cmd_i      <= pending_reqs[0].cmd;
        src_col_i  <= pending_reqs[0].scol;
        src_row_i  <= pending_reqs[0].srow;
        red_in_i   <= pending_reqs[0].px.red;
        green_in_i <= pending_reqs[0].px.green;
        blue_in_i  <= pending_reqs[0].px.blue;
        out_col_i  <= pending_reqs[0].ocol;
        out_row_i  <= pending_reqs[0].orow;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each output pixel is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_pix.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h %h %h %h", $realtime,
                 alpha_out_o, red_out_o, green_out_o, blue_out_o);
        errors++;
      end else begin
        if (alpha_out_o !== ALPHA_OPAQUE || red_out_o !== expected_pix[0].red ||
            green_out_o !== expected_pix[0].green || blue_out_o !== expected_pix[0].blue) begin
          $display("%0t: mismatch expected %h %h %h %h actual %h %h %h %h", $realtime,
                   ALPHA_OPAQUE, expected_pix[0].red, expected_pix[0].green,
                   expected_pix[0].blue, alpha_out_o, red_out_o, green_out_o, blue_out_o);
          errors++;
        end
        n_checked++;
        void'(expected_pix.pop_front());
      end
    end
  end

  task automatic push_load(input int col, input int row, input pixel_t px);
    request_t r;
    r = '0;
    r.cmd = CMD_LOAD;
    r.scol = SRC_C_W'(col);
    r.srow = SRC_C_W'(row);
    r.px = px;
    r.ocol = COORD_W'($urandom);
    r.orow = COORD_W'($urandom);
    if (col < SRC_W && row < SRC_H) loaded[row * SRC_W + col] = 1'b1;
    pending_reqs.push_back(r);
  endtask

  // Loads any of the four neighbors not yet written, then the query itself.
  task automatic push_query(input int col, input int row);
    request_t    r;
    int unsigned xi, yi;
    int          fx, fy;
    map_axis(col, gen_w, SRC_W, xi, fx);
    map_axis(row, gen_h, SRC_H, yi, fy);
    for (int dy = 0; dy < 2; dy++)
      for (int dx = 0; dx < 2; dx++)
        if (!loaded[(yi + dy) * SRC_W + xi + dx])
          push_load(xi + dx, yi + dy, pixel_t'($urandom));
    r = '0;
    r.cmd = CMD_QUERY;
    r.scol = SRC_C_W'($urandom);
    r.srow = SRC_C_W'($urandom);
    r.px = pixel_t'($urandom);
    r.ocol = COORD_W'(col);
    r.orow = COORD_W'(row);
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_OUT_WIDTH) frame_w = sat_size(val);
    else frame_h = sat_size(val);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(CFG_OUT_WIDTH, w);
    write_reg(CFG_OUT_HEIGHT, h);
    gen_w = sat_size(w);
    gen_h = sat_size(h);
  endtask

  // Waits for every request and result, then lets the pipeline settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_pix.size() > 0 || start)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Random mix: mostly in-frame queries, some off-frame, loads incl. ignored ones.
  task automatic random_mix(input int count);
    int w, h;
    w = (gen_w > 0) ? gen_w : 1;
    h = (gen_h > 0) ? gen_h : 1;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 9) == 0) push_load($urandom_range(0, 511),
                                                 $urandom_range(0, 511), pixel_t'($urandom));
        else push_load($urandom_range(0, SRC_W - 1), $urandom_range(0, SRC_H - 1),
                       pixel_t'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        push_query($urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        push_query($urandom_range(0, w - 1), $urandom_range(0, h - 1));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner loads, ignored loads, frame corners and beyond.
    push_load(0, 0, 24'h000000);
    push_load(1, 0, 24'hFFFFFF);
    push_load(0, 1, 24'hFF00FF);
    push_load(1, 1, 24'h00FF00);
    push_load(SRC_W - 1, SRC_H - 1, 24'hFFFFFF);
    push_load(511, 511, 24'hFFFFFF);
    push_load(SRC_W, 0, 24'h123456);
    push_load(0, SRC_H, 24'h654321);
    push_query(0, 0);
    push_query(1, 1);
    push_query(383, 287);
    push_query(384, 288);
    push_query(4095, 4095);
    push_query(191, 143);
    drain();

    set_size(13'd1, 13'd1);
    push_query(0, 0);
    push_query(1, 0);
    push_query(4095, 4095);
    random_mix(60);
    drain();

    set_size(13'd0, 13'd8191);
    push_query(0, 4095);
    random_mix(60);
    drain();

    set_size(13'd4096, 13'd4096);
    push_query(4095, 4095);
    push_query(4094, 1);
    random_mix(70);
    drain();

    set_size(13'd2, 13'd3);
    no_gaps = 1'b1;
    random_mix(80);
    drain();
    no_gaps = 1'b0;

    set_size(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    random_mix(45);
    repeat (40) @(posedge clk_i);
    hold_sender <= 1'b1;
    @(posedge clk_i);
    while (expected_pix.size() > 0 || start) @(posedge clk_i);
    hold_sender <= 1'b0;
    random_mix(45);
    drain();

    set_size(13'd5000, 13'd700);
    random_mix(65);
    drain();

    $display("Covered %0d loads and %0d queries, %0d output pixels checked, %0d errors.",
             n_loads, n_queries, n_checked, errors);
    $display("Sizes ran from zero and one up to the saturated maximum.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bris_pkg.sv
design/bris_div.sv
design/bris_bank.sv
design/bris_mix.sv
design/bilinear_rgb_image_scaler.sv
design/bris_chk.sv
verif/testbench.sv
